/* rtl/swdot_pkg.sv */
package swdot_pkg;

  // Field widths.
  localparam int TIME_W  = 32;
  localparam int SPEED_W = 24;
  localparam int POS_W   = 17;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = TIME_W + SPEED_W;

  // Fixed-point constants with 16 fraction bits (Q1.16 and Q2.16).
  localparam logic [POS_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [POS_W:0]   TWO_Q16 = 18'd131072;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_PHASE = 7'b0000100,
    ST_SQ1   = 7'b0001000,
    ST_SQ2   = 7'b0010000,
    ST_SQ3   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

endpackage

/* rtl/swdot_mul.sv */
module swdot_mul (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic signed [swdot_pkg::TIME_W-1:0]        a,
  input  logic signed [swdot_pkg::SPEED_W-1:0]       b,
  output logic signed [swdot_pkg::PROD_W-1:0]        prod
);

  logic signed [swdot_pkg::PROD_W-1:0] prod_r;

  // Shared signed multiplier with a registered product.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= swdot_pkg::PROD_W'(a) * swdot_pkg::PROD_W'(b);
    end
  end

  assign prod = prod_r;

endmodule

/* rtl/sweeping_dot_brightness_unit.sv */
// Channel  | Direction | Ports
// ---------+-----------+------------------------------------------------------
// in       | input     | in_valid, in_stall, in_current_time, in_speed_ratio,
//          |           | in_led_position
// out      | output    | out_valid, out_stall, out_brightness
// cfg      | input     | cfg_we, cfg_wdata (rotate mode)
//
// A word passes from acceptance to the result register through MUL, PHASE,
// SQ1, SQ2, SQ3 and OUT: the shared multiplier runs four times (speed
// product, three squarings), with PHASE between for the phase update and the
// dot distance. The next word is taken in IDLE once the last has left OUT, even
// while that result is stalled; a stalled result holds the block in OUT.
// Synchronous active-low reset clears the time, the phase and rotate mode.
module sweeping_dot_brightness_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic                                   cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [swdot_pkg::TIME_W-1:0]           in_current_time,
  input  logic signed [swdot_pkg::SPEED_W-1:0]   in_speed_ratio,
  input  logic [swdot_pkg::POS_W-1:0]            in_led_position,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [swdot_pkg::POS_W-1:0]            out_brightness
);

  swdot_pkg::state_t state_r, state_nxt;

  logic                                  rotate_mode_r;
  logic [swdot_pkg::TIME_W-1:0]          last_time_r;
  logic [swdot_pkg::FRAC_W-1:0]          phase_r, phase_nxt;
  logic [swdot_pkg::TIME_W-1:0]          diff_r;
  logic signed [swdot_pkg::SPEED_W-1:0]  spd_r;
  logic [swdot_pkg::POS_W-1:0]           led_r;
  logic [swdot_pkg::POS_W-1:0]           v_r, v_nxt;
  logic                                  out_valid_r;
  logic [swdot_pkg::POS_W-1:0]           out_brightness_r;

  logic                                  accept;
  logic                                  out_free;
  logic                                  mul_en;
  logic                                  sq_sel;
  logic [swdot_pkg::POS_W-1:0]           sq_src;
  logic signed [swdot_pkg::TIME_W-1:0]   mul_a;
  logic signed [swdot_pkg::SPEED_W-1:0]  mul_b;
  logic signed [swdot_pkg::PROD_W-1:0]   prod;
  logic [swdot_pkg::POS_W-1:0]           sq_val;

  logic [swdot_pkg::POS_W-1:0]           p2;
  logic [swdot_pkg::POS_W-1:0]           pos;
  logic [swdot_pkg::POS_W-1:0]           led_offset;
  logic [swdot_pkg::POS_W-1:0]           fold;

  assign in_stall       = (state_r != swdot_pkg::ST_IDLE);
  assign accept         = in_valid && !in_stall;
  assign out_free       = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_brightness = out_brightness_r;

  // Squared value in Q1.16 taken from the product register.
  assign sq_val = prod[swdot_pkg::FRAC_W + swdot_pkg::POS_W - 1:swdot_pkg::FRAC_W];

  // Operand selection for the shared multiplier.
  assign sq_sel = (state_r == swdot_pkg::ST_SQ1) || (state_r == swdot_pkg::ST_SQ2) ||
                  (state_r == swdot_pkg::ST_SQ3);
  assign sq_src = (state_r == swdot_pkg::ST_SQ1) ? v_r : sq_val;
  assign mul_a  = sq_sel ? swdot_pkg::TIME_W'(sq_src) : diff_r;
  assign mul_b  = sq_sel ? swdot_pkg::SPEED_W'(sq_src) : spd_r;
  assign mul_en = (state_r == swdot_pkg::ST_MUL) || sq_sel;

  swdot_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Phase update and distance of the dot from this LED.
  always_comb begin
    phase_nxt = phase_r + prod[2*swdot_pkg::FRAC_W-1:swdot_pkg::FRAC_W];
    p2        = {phase_nxt, 1'b0};
    if (rotate_mode_r) begin
      pos = swdot_pkg::POS_W'(phase_nxt);
    end else if (p2[swdot_pkg::POS_W-1]) begin
      pos = swdot_pkg::POS_W'(swdot_pkg::TWO_Q16 - {1'b0, p2});
    end else begin
      pos = p2;
    end
    led_offset = (pos >= led_r) ? pos - led_r : led_r - pos;
    if (led_offset <= swdot_pkg::ONE_Q16) begin
      fold = swdot_pkg::ONE_Q16 - led_offset;
    end else begin
      fold = led_offset - swdot_pkg::ONE_Q16;
    end
    v_nxt = (fold > swdot_pkg::ONE_Q16) ? swdot_pkg::ONE_Q16 : fold;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swdot_pkg::ST_IDLE:  if (accept) state_nxt = swdot_pkg::ST_MUL;
      swdot_pkg::ST_MUL:   state_nxt = swdot_pkg::ST_PHASE;
      swdot_pkg::ST_PHASE: state_nxt = swdot_pkg::ST_SQ1;
      swdot_pkg::ST_SQ1:   state_nxt = swdot_pkg::ST_SQ2;
      swdot_pkg::ST_SQ2:   state_nxt = swdot_pkg::ST_SQ3;
      swdot_pkg::ST_SQ3:   state_nxt = swdot_pkg::ST_OUT;
      swdot_pkg::ST_OUT:   if (out_free) state_nxt = swdot_pkg::ST_IDLE;
      default:             state_nxt = swdot_pkg::ST_IDLE;
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= swdot_pkg::ST_IDLE;
      rotate_mode_r <= 1'b0;
      last_time_r   <= '0;
      phase_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        rotate_mode_r <= cfg_wdata;
      end
      if (accept) begin
        last_time_r <= in_current_time;
      end
      if (state_r == swdot_pkg::ST_PHASE) begin
        phase_r <= phase_nxt;
      end
      if (state_r == swdot_pkg::ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      diff_r <= in_current_time - last_time_r;
      spd_r  <= in_speed_ratio;
      led_r  <= in_led_position;
    end
    if (state_r == swdot_pkg::ST_PHASE) begin
      v_r <= v_nxt;
    end
    if (state_r == swdot_pkg::ST_OUT && out_free) begin
      out_brightness_r <= sq_val;
    end
  end

endmodule
